// ----- design/mipd_pkg.sv -----
`timescale 1ns / 1ps

package mipd_pkg;

	// Coordinate bits actually used; inputs are sign extended from COORD_BITS-1.
	localparam int COORD_BITS = 32;
	localparam int PORT_W     = 32;
	localparam int LEN_W      = 31;

	// Magnitude of an axis difference always fits COORD_BITS bits.
	localparam int MAG_W  = COORD_BITS;
	// Dividend 2*mag + len and divisor 2*len of the rounding divide.
	localparam int N_W    = ((MAG_W + 1 > LEN_W) ? MAG_W + 1 : LEN_W) + 1;
	localparam int D_W    = LEN_W + 1;

	localparam int SQ_W   = 64;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_PERIODIC_ON  = 2'd0,
		REG_BOX_LENGTH_X = 2'd1,
		REG_BOX_LENGTH_Y = 2'd2,
		REG_BOX_LENGTH_Z = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             periodic_on;
		logic [LEN_W-1:0] box_length;
	} axis_cfg_t;

	typedef struct packed {
		logic vld;
		logic ovf;
	} pipe_tag_t;

endpackage

// ----- design/mipd_axis.sv -----
`timescale 1ns / 1ps

module mipd_axis (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  mipd_pkg::axis_cfg_t      cfg,
	input  logic                     in_vld,
	input  logic [mipd_pkg::PORT_W-1:0] coord_a,
	input  logic [mipd_pkg::PORT_W-1:0] coord_b,
	output logic                     out_vld,
	output logic [mipd_pkg::MAG_W-1:0] out_mag
);
	import mipd_pkg::*;

	logic signed [COORD_BITS:0] diff_c;
	logic [MAG_W-1:0]           mag_s1;
	logic                       vld_s1;
	logic [N_W-1:0]             num_c;
	logic [D_W-1:0]             den_c;

	logic [D_W-1:0]   rem_s [N_W];
	logic [N_W-1:0]   nsh_s [N_W];
	logic [MAG_W-1:0] mag_s [N_W];
	logic             vld_s [N_W];

	logic [D_W-1:0]        rem_fin;
	logic signed [D_W+1:0] dev_c;
	logic [D_W+1:0]        dev_abs;
	logic [MAG_W-1:0]      wrap_c;
	logic [MAG_W-1:0]      res_mag_s;
	logic                  res_vld_s;

	assign diff_c = $signed({coord_b[COORD_BITS-1], coord_b[COORD_BITS-1:0]})
		- $signed({coord_a[COORD_BITS-1], coord_a[COORD_BITS-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= diff_c[COORD_BITS] ? MAG_W'(-diff_c) : diff_c[COORD_BITS-1:0];
		end
	end

	// q = (2*mag + len) / (2*len); only the remainder is needed
	assign num_c = N_W'({mag_s1, 1'b0}) + N_W'(cfg.box_length);
	assign den_c = {cfg.box_length, 1'b0};

	for (genvar k = 0; k < N_W; k++) begin : g_div
		logic [D_W-1:0]   rem_in;
		logic [N_W-1:0]   n_in;
		logic [MAG_W-1:0] mag_in;
		logic             v_in;
		logic [D_W:0]     trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign n_in   = num_c;
			assign mag_in = mag_s1;
			assign v_in   = vld_s1;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign n_in   = nsh_s[k-1];
			assign mag_in = mag_s[k-1];
			assign v_in   = vld_s[k-1];
		end

		assign trial = {rem_in, n_in[N_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= (trial >= {1'b0, den_c}) ? D_W'(trial - {1'b0, den_c})
					: trial[D_W-1:0];
				nsh_s[k] <= {n_in[N_W-2:0], 1'b0};
				mag_s[k] <= mag_in;
			end
		end
	end

	// mag - q*len = (rem - len) / 2
	assign rem_fin = rem_s[N_W-1];
	assign dev_c   = $signed({2'b00, rem_fin}) - $signed({3'b000, cfg.box_length});
	assign dev_abs = dev_c[D_W+1] ? (D_W+2)'(-dev_c) : dev_c;
	assign wrap_c  = MAG_W'(dev_abs[D_W+1:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s <= 1'b0;
		end else if (en) begin
			res_vld_s <= vld_s[N_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_mag_s <= (cfg.periodic_on && (cfg.box_length != '0)) ? wrap_c
				: mag_s[N_W-1];
		end
	end

	assign out_vld = res_vld_s;
	assign out_mag = res_mag_s;

endmodule

// ----- design/mipd_sqrt.sv -----
`timescale 1ns / 1ps

module mipd_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  mipd_pkg::pipe_tag_t         in_tag,
	input  logic [mipd_pkg::SQ_W-1:0]   in_sq,
	output mipd_pkg::pipe_tag_t         out_tag,
	output logic [mipd_pkg::SQ_W-1:0]   out_sq,
	output logic [mipd_pkg::ROOT_W-1:0] out_root
);
	import mipd_pkg::*;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SQ_W-1:0]   vsh_s  [ROOT_W];
	logic [SQ_W-1:0]   sq_s   [ROOT_W];
	logic              ovf_s  [ROOT_W];
	logic              vld_s  [ROOT_W];

	// one result bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   v_in;
		logic [SQ_W-1:0]   sq_in;
		logic              ovf_in;
		logic              vld_in;
		logic [REM_W+1:0]  rem2;
		logic [REM_W+1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = in_sq;
			assign sq_in   = in_sq;
			assign ovf_in  = in_tag.ovf;
			assign vld_in  = in_tag.vld;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign v_in    = vsh_s[k-1];
			assign sq_in   = sq_s[k-1];
			assign ovf_in  = ovf_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		assign rem2  = {rem_in, v_in[SQ_W-1:SQ_W-2]};
		assign trial = (REM_W+2)'({root_in, 2'b01});
		assign take  = (rem2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], take};
				vsh_s[k]  <= {v_in[SQ_W-3:0], 2'b00};
				sq_s[k]   <= sq_in;
				ovf_s[k]  <= ovf_in;
			end
		end
	end

	assign out_tag.vld = vld_s[ROOT_W-1];
	assign out_tag.ovf = ovf_s[ROOT_W-1];
	assign out_sq      = sq_s[ROOT_W-1];
	assign out_root    = root_s[ROOT_W-1];

endmodule

// ----- design/minimum_image_pair_distance_unit.sv -----
`timescale 1ns / 1ps

// Minimum-image pair distance. Takes two 3D points (signed Q16.16) per request
// and returns the squared distance (unsigned Q32.32, saturating, with an
// overflow flag) and the distance (unsigned Q16.16, truncated square root).
// With periodic_on set, every axis difference is wrapped to the nearest image
// using its box length (halves round away from zero); a box length of zero
// leaves that axis unwrapped. Fully pipelined: one request per cycle while no
// result is held; the steps are per-axis difference, rounding divide and wrap,
// then square and sum, then square root. A stalled result freezes the whole pipe,
// so in_stall follows out_stall while a result is waiting. Configure over APB only while idle.
module minimum_image_pair_distance_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mipd_pkg::APB_AW-1:0]  paddr,
	input  logic [mipd_pkg::APB_DW-1:0]  pwdata,
	output logic [mipd_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mipd_pkg::PORT_W-1:0]  point_a_x,
	input  logic [mipd_pkg::PORT_W-1:0]  point_a_y,
	input  logic [mipd_pkg::PORT_W-1:0]  point_a_z,
	input  logic [mipd_pkg::PORT_W-1:0]  point_b_x,
	input  logic [mipd_pkg::PORT_W-1:0]  point_b_y,
	input  logic [mipd_pkg::PORT_W-1:0]  point_b_z,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mipd_pkg::SQ_W-1:0]    squared_length,
	output logic [mipd_pkg::ROOT_W-1:0]  length,
	output logic                         overflowed
);
	import mipd_pkg::*;

	logic             periodic_on_q;
	logic [LEN_W-1:0] box_length_x_q;
	logic [LEN_W-1:0] box_length_y_q;
	logic [LEN_W-1:0] box_length_z_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	logic      adv;
	axis_cfg_t cfg_x, cfg_y, cfg_z;

	logic             vld_x, vld_y, vld_z;
	logic [MAG_W-1:0] mag_x, mag_y, mag_z;

	logic [SQ_W-1:0]   sq_x_s1, sq_y_s1, sq_z_s1;
	logic              vld_s1;
	logic [SQ_W:0]     sum_xy_s2;
	logic [SQ_W-1:0]   sq_z_s2;
	logic              vld_s2;
	logic [SQ_W+1:0]   total_c;
	logic              ovf_c;
	logic [SQ_W-1:0]   sqlen_s3;
	pipe_tag_t         tag_s3;
	pipe_tag_t         tag_out;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_on_q  <= 1'b1;
			box_length_x_q <= LEN_W'(65536);
			box_length_y_q <= LEN_W'(65536);
			box_length_z_q <= LEN_W'(65536);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PERIODIC_ON:  periodic_on_q  <= pwdata[0];
				REG_BOX_LENGTH_X: box_length_x_q <= pwdata[LEN_W-1:0];
				REG_BOX_LENGTH_Y: box_length_y_q <= pwdata[LEN_W-1:0];
				REG_BOX_LENGTH_Z: box_length_z_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PERIODIC_ON:  prdata = APB_DW'(periodic_on_q);
			REG_BOX_LENGTH_X: prdata = APB_DW'(box_length_x_q);
			REG_BOX_LENGTH_Y: prdata = APB_DW'(box_length_y_q);
			REG_BOX_LENGTH_Z: prdata = APB_DW'(box_length_z_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	// whole pipe advances unless the finished result is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign cfg_x = '{periodic_on: periodic_on_q, box_length: box_length_x_q};
	assign cfg_y = '{periodic_on: periodic_on_q, box_length: box_length_y_q};
	assign cfg_z = '{periodic_on: periodic_on_q, box_length: box_length_z_q};

	// ---------------- per-axis difference and wrap ----------------
	mipd_axis u_axis_x (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg_x), .in_vld(in_valid),
		.coord_a(point_a_x), .coord_b(point_b_x), .out_vld(vld_x), .out_mag(mag_x)
	);
	mipd_axis u_axis_y (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg_y), .in_vld(in_valid),
		.coord_a(point_a_y), .coord_b(point_b_y), .out_vld(vld_y), .out_mag(mag_y)
	);
	mipd_axis u_axis_z (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg_z), .in_vld(in_valid),
		.coord_a(point_a_z), .coord_b(point_b_z), .out_vld(vld_z), .out_mag(mag_z)
	);

	// ---------------- squares and sum ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			tag_s3 <= '0;
		end else if (adv) begin
			vld_s1     <= vld_x && vld_y && vld_z;
			vld_s2     <= vld_s1;
			tag_s3.vld <= vld_s2;
			tag_s3.ovf <= ovf_c;
		end
	end

	// sum of three squares can reach 2^64 or more; flag it
	assign total_c = (SQ_W+2)'(sum_xy_s2) + (SQ_W+2)'(sq_z_s2);
	assign ovf_c   = (total_c[SQ_W+1:SQ_W] != 2'b00);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s1   <= SQ_W'(mag_x) * SQ_W'(mag_x);
			sq_y_s1   <= SQ_W'(mag_y) * SQ_W'(mag_y);
			sq_z_s1   <= SQ_W'(mag_z) * SQ_W'(mag_z);
			sum_xy_s2 <= (SQ_W+1)'(sq_x_s1) + (SQ_W+1)'(sq_y_s1);
			sq_z_s2   <= sq_z_s1;
			sqlen_s3  <= ovf_c ? '1 : total_c[SQ_W-1:0];
		end
	end

	// ---------------- square root ----------------
	mipd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_tag(tag_s3), .in_sq(sqlen_s3),
		.out_tag(tag_out), .out_sq(squared_length), .out_root(length)
	);

	assign out_valid  = tag_out.vld;
	assign overflowed = tag_out.ovf;

endmodule

// ----- design/mipd_checker.sv -----
`timescale 1ns / 1ps

module mipd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mipd_pkg::SQ_W-1:0]    squared_length,
	input logic [mipd_pkg::ROOT_W-1:0]  length,
	input logic                         overflowed
);
	import mipd_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(squared_length)
			&& $stable(length) && $stable(overflowed))
		else $error("result changed while stalled");

	// nothing waiting at the output means requests are taken
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// saturation forces the all-ones square and root
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> (squared_length == '1) && (length == '1))
		else $error("overflow without saturation");

	// root never exceeds the floor: length^2 <= squared_length
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (SQ_W'(length) * SQ_W'(length)) <= squared_length)
		else $error("root too large");

endmodule

bind minimum_image_pair_distance_unit mipd_checker u_mipd_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .squared_length(squared_length),
	.length(length), .overflowed(overflowed)
);

// ----- tb/sv/minimum_image_pair_distance_unit_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the minimum-image pair distance unit.
// A distance predictor mirrors the block's arithmetic; each accepted request
// pushes its expected squared length, length and overflow flag, and every
// accepted result is checked against the oldest of those.
class distance_scoreboard;
	bit periodic;
	bit [30:0] box [3];
	bit [63:0] exp_sq [$];
	bit [31:0] exp_len [$];
	bit exp_ovf [$];
	int errors;

	function new();
		periodic = 1'b1;
		box[0] = 31'd65536;
		box[1] = 31'd65536;
		box[2] = 31'd65536;
		errors = 0;
	endfunction

	// magnitude of one axis difference, wrapped to the nearest image if enabled
	function bit [63:0] axis_mag(bit [31:0] a, bit [31:0] b, bit [30:0] len);
		longint d;
		bit [63:0] mag;
		bit [63:0] q;
		longint r;
		d = longint'($signed(b)) - longint'($signed(a));
		mag = (d < 0) ? -d : d;
		if (periodic && len != 0) begin
			q = (2 * mag + len) / (2 * {33'd0, len});
			r = longint'(mag) - longint'(q * len);
			mag = (r < 0) ? -r : r;
		end
		return mag;
	endfunction

	function bit [31:0] int_root(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res[31:0];
	endfunction

	function void note_request(bit [31:0] p [6]);
		bit [63:0] mags [3];
		bit [63:0] sum;
		bit [63:0] sq;
		bit ovf;
		sum = 0;
		ovf = 0;
		for (int i = 0; i < 3; i++)
			mags[i] = axis_mag(p[i], p[i+3], box[i]);
		for (int i = 0; i < 3; i++) begin
			if (!ovf) begin
				if (mags[i] > 64'hFFFF_FFFF) ovf = 1;
				else begin
					sq = mags[i] * mags[i];
					if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ovf = 1;
					else sum = sum + sq;
				end
			end
		end
		if (ovf) sum = '1;
		exp_sq.push_back(sum);
		exp_len.push_back(int_root(sum));
		exp_ovf.push_back(ovf);
	endfunction

	function void check_result(bit [63:0] sq, bit [31:0] len, bit ovf);
		bit [63:0] e_sq;
		bit [31:0] e_len;
		bit e_ovf;
		if (exp_sq.size() == 0) begin
			$error("result with no pending request");
			errors++;
			return;
		end
		e_sq = exp_sq.pop_front();
		e_len = exp_len.pop_front();
		e_ovf = exp_ovf.pop_front();
		if (sq !== e_sq) begin
			$error("squared_length expected %h got %h", e_sq, sq);
			errors++;
		end
		if (len !== e_len) begin
			$error("length expected %h got %h", e_len, len);
			errors++;
		end
		if (ovf !== e_ovf) begin
			$error("overflowed expected %b got %b", e_ovf, ovf);
			errors++;
		end
	endfunction
endclass

module minimum_image_pair_distance_unit_test;
	import mipd_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [31:0] point_a_x, point_a_y, point_a_z;
	logic [31:0] point_b_x, point_b_y, point_b_z;
	logic out_valid, out_stall;
	logic [63:0] squared_length;
	logic [31:0] length;
	logic overflowed;

	distance_scoreboard sb;
	bit wide_box;  // when set, random boxes span the full register range

	minimum_image_pair_distance_unit uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// generous hard limit: ~2000 requests with long gaps plus pipe latency
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// short gaps mostly, an occasional long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// APB write: setup cycle then access cycle, driven on falling edges
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_PERIODIC_ON) sb.periodic = val[0];
		else sb.box[int'(idx) - 1] = val[30:0];
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// stop sending, wait for all results, then let the pipe drain its latency
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.exp_sq.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic send(bit [31:0] p [6]);
		@(negedge clk);
		in_valid = 1;
		{point_a_x, point_a_y, point_a_z} = {p[0], p[1], p[2]};
		{point_b_x, point_b_y, point_b_z} = {p[3], p[4], p[5]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(p);
		repeat (gap_len()) begin
			@(negedge clk);
			in_valid = 0;
			@(posedge clk);
		end
	endtask

	// random coordinate: full range, extremes, or near a box-size boundary
	function automatic bit [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
			2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	task automatic send_random();
		bit [31:0] p [6];
		for (int i = 0; i < 6; i++) p[i] = rand_coord();
		// half-box offsets exercise the round-half-away case
		if ($urandom_range(0, 7) == 0) p[3] = p[0] + {1'b0, sb.box[0]} / 2;
		send(p);
	endtask

	function automatic bit [30:0] rand_box();
		case ($urandom_range(0, 4))
			0: return 31'd1;
			1: return 31'h7FFF_FFFF;
			2: return wide_box ? 31'($urandom()) : 31'($urandom_range(1, 32'h0004_0000));
			3: return 31'd0;  // unwrapped axis
			default: return 31'($urandom_range(1, 32'h0004_0000));
		endcase
	endfunction

	// receiver stall pattern
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall = 0;
			repeat (gap_len()) @(negedge clk);
			out_stall = ($urandom_range(0, 1) == 1);
			repeat (gap_len()) @(negedge clk);
		end
	end

	// result checker, sampled on rising edges
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(squared_length, length, overflowed);
	end

	initial begin
		bit [31:0] p [6];
		sb = new();
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0;
		{point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z} = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n = 1;

		// directed: reset configuration, extremes and half-box cases
		p = '{0, 0, 0, 0, 0, 0};
		send(p);
		p = '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0};
		send(p);
		p = '{0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000};
		send(p);
		p = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF};
		send(p);
		drain();

		// plain differences with saturation
		reg_write(REG_PERIODIC_ON, 32'hFFFF_FFFE);
		reg_write(REG_PERIODIC_ON, 32'h0);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send(p);
		p = '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0};
		send(p);
		p = '{0, 32'h8000_0000, 0, 0, 32'h0000_0001, 0};
		send(p);
		p = '{0, 0, 0, 32'h7FFF_FFFF, 32'hB504_F334, 0};
		send(p);
		drain();

		// periodic with extreme and zero box lengths
		reg_write(REG_PERIODIC_ON, 32'h1);
		reg_write(REG_BOX_LENGTH_X, 32'hFFFF_FFFF);
		reg_write(REG_BOX_LENGTH_Y, 32'h0);
		reg_write(REG_BOX_LENGTH_Z, 32'h1);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send(p);
		p = '{0, 0, 0, 32'h3FFF_FFFF, 32'h1234_5678, 32'h0000_0003};
		send(p);
		p = '{0, 0, 0, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFD};
		send(p);
		drain();

		// random phases, each with a new configuration
		for (int ph = 0; ph < 13; ph++) begin
			wide_box = ($urandom_range(0, 1) == 1);
			reg_write(REG_PERIODIC_ON, (ph % 4 == 3) ? 0 : $urandom());
			reg_write(REG_BOX_LENGTH_X, {1'($urandom_range(0, 1)), rand_box()});
			reg_write(REG_BOX_LENGTH_Y, {1'($urandom_range(0, 1)), rand_box()});
			reg_write(REG_BOX_LENGTH_Z, {1'($urandom_range(0, 1)), rand_box()});
			for (int n = 0; n < 150; n++) begin
				send_random();
				// sender holds off once until the pipe is empty
				if (ph == 5 && n == 70) begin
					@(negedge clk);
					in_valid = 0;
					while (sb.exp_sq.size() != 0) @(posedge clk);
				end
			end
			@(negedge clk);
			in_valid = 0;
			drain();
		end

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
